>>> src/vt100_subset_terminal_parser_assert.svh
`ifndef VT100_SUBSET_TERMINAL_PARSER_ASSERT_SVH
`define VT100_SUBSET_TERMINAL_PARSER_ASSERT_SVH

// Assertion helpers; the including module provides clk_i and rst_ni.

// Same-cycle implication.
`define VTP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vtp: implication check failed");

// Next-cycle implication.
`define VTP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vtp: next-cycle check failed");

`endif

>>> src/vtp_pkg.sv
package vtp_pkg;

  // configuration port
  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned RegIdxBit    = 2;

  // fixed field widths of a result beat
  localparam int unsigned FieldWidth = 5;

  localparam int unsigned ResultCap      = 20;
  localparam int unsigned CapWidth       = 5;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned BottomRowReset = 14;

  // control bytes
  localparam logic [7:0] ChBel      = 8'h07;
  localparam logic [7:0] ChBs       = 8'h08;
  localparam logic [7:0] ChLf       = 8'h0a;
  localparam logic [7:0] ChCr       = 8'h0d;
  localparam logic [7:0] ChEsc      = 8'h1b;
  localparam logic [7:0] ChDel      = 8'h7f;
  localparam logic [7:0] ChLbracket = 8'h5b;
  localparam logic [7:0] ChSemi     = 8'h3b;
  localparam logic [7:0] ChAt       = 8'h40;
  localparam logic [7:0] ChTilde    = 8'h7e;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChNine     = 8'h39;

  // CSI finals
  localparam logic [7:0] FinCup = 8'h48;  // H
  localparam logic [7:0] FinHvp = 8'h66;  // f
  localparam logic [7:0] FinCuu = 8'h41;  // A
  localparam logic [7:0] FinCud = 8'h42;  // B
  localparam logic [7:0] FinCuf = 8'h43;  // C
  localparam logic [7:0] FinCub = 8'h44;  // D
  localparam logic [7:0] FinEd  = 8'h4a;  // J
  localparam logic [7:0] FinEl  = 8'h4b;  // K
  localparam logic [7:0] FinSgr = 8'h6d;  // m

  localparam logic [7:0] SgrReverse  = 8'd7;
  localparam logic [7:0] ModeCursor  = 8'd1;
  localparam logic [7:0] ModeAll     = 8'd2;

  typedef enum logic [1:0] {
    CMD_GLYPH  = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SCROLL = 2'd2,
    CMD_BEEP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_GLYPH,
    OP_BEEP,
    OP_CR,
    OP_LF,
    OP_BS,
    OP_CSI
  } op_kind_e;

  typedef enum logic [1:0] {
    ERASE_TO_END    = 2'd0,
    ERASE_TO_CURSOR = 2'd1,
    ERASE_ALL       = 2'd2
  } erase_mode_e;

  // classified byte handed from parser to executor
  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] chr;
    logic [7:0] p0;
    logic [7:0] p1;
  } op_t;

  // one result beat
  typedef struct packed {
    logic                  valid;
    cmd_e                  command;
    logic [7:0]            glyph;
    logic [FieldWidth-1:0] cell_row;
    logic [FieldWidth-1:0] col_first;
    logic [FieldWidth-1:0] col_last;
    logic                  inverse;
    logic                  last;
  } beat_t;

  // register write toward the executor
  typedef struct packed {
    logic                  wr;
    logic [FieldWidth-1:0] value;
  } cfg_wr_t;

endpackage

>>> src/vtp_front.sv
module vtp_front #(
  parameter int unsigned MAX_VALUES = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       byte_in_i,
  output logic             in_stall_o,
  input  logic             full_i,
  output logic             push_o,
  output vtp_pkg::op_t     op_o
);
  import vtp_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_VALUES);

  typedef enum logic [2:0] {
    PH_TEXT = 3'b001,
    PH_ESC  = 3'b010,
    PH_CSI  = 3'b100
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      vals_q [MAX_VALUES];
  logic [7:0]      vals_d [MAX_VALUES];
  logic [IdxW-1:0] idx_q, idx_d;
  logic            accept;
  logic            is_digit;
  logic            is_final;
  logic [11:0]     acc;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;
  assign is_digit   = (byte_in_i >= ChZero) && (byte_in_i <= ChNine);
  assign is_final   = (byte_in_i >= ChAt) && (byte_in_i <= ChTilde);
  // v*10 + digit, at most 2559
  assign acc = ({4'd0, vals_q[idx_q]} << 3) + ({4'd0, vals_q[idx_q]} << 1)
             + {8'd0, byte_in_i[3:0]};

  always_comb begin
    phase_d = phase_q;
    vals_d  = vals_q;
    idx_d   = idx_q;
    push_o  = 1'b0;
    op_o    = '{kind: OP_GLYPH, chr: byte_in_i, p0: vals_q[0], p1: vals_q[1]};
    if (accept) begin
      unique case (phase_q)
        PH_TEXT: begin
          priority if (byte_in_i == ChEsc) begin
            phase_d = PH_ESC;
          end else if (byte_in_i == ChDel) begin
            push_o = 1'b0;
          end else begin
            push_o = 1'b1;
            priority if (byte_in_i == ChBel) op_o.kind = OP_BEEP;
            else if (byte_in_i == ChCr)      op_o.kind = OP_CR;
            else if (byte_in_i == ChLf)      op_o.kind = OP_LF;
            else if (byte_in_i == ChBs)      op_o.kind = OP_BS;
            else                             op_o.kind = OP_GLYPH;
          end
        end
        PH_ESC: begin
          if (byte_in_i == ChLbracket) begin
            phase_d = PH_CSI;
            idx_d   = '0;
            for (int i = 0; i < MAX_VALUES; i++) vals_d[i] = 8'd0;
          end else begin
            phase_d = PH_TEXT;
          end
        end
        PH_CSI: begin
          priority if (is_digit) begin
            vals_d[idx_q] = (acc > 12'd255) ? 8'd255 : acc[7:0];
          end else if (byte_in_i == ChSemi) begin
            if (idx_q != IdxW'(MAX_VALUES - 1)) idx_d = idx_q + 1'b1;
          end else begin
            push_o    = is_final;
            op_o.kind = OP_CSI;
            phase_d   = PH_TEXT;
          end
        end
        default: phase_d = PH_TEXT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TEXT;
      idx_q   <= '0;
      for (int i = 0; i < MAX_VALUES; i++) vals_q[i] <= 8'd0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      vals_q  <= vals_d;
    end
  end

endmodule

>>> src/vtp_fifo.sv
module vtp_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  vtp_pkg::op_t op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output vtp_pkg::op_t op_o
);
  import vtp_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  op_t             mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign op_o    = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> src/vtp_back.sv
module vtp_back #(
  parameter int unsigned TEXT_COLUMNS = 30,
  parameter int unsigned TEXT_ROWS    = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  vtp_pkg::cfg_wr_t                cfg_i,
  output logic [vtp_pkg::FieldWidth-1:0]  bottom_row_o,
  input  logic                            empty_i,
  input  vtp_pkg::op_t                    op_i,
  output logic                            pop_o,
  input  logic                            out_stall_i,
  output vtp_pkg::beat_t                  beat_o
);
  import vtp_pkg::*;

  localparam int unsigned ColW = $clog2(TEXT_COLUMNS + 1);
  localparam int unsigned RowW = $clog2(TEXT_ROWS);
  localparam logic [ColW-1:0] LastCol = ColW'(TEXT_COLUMNS - 1);
  localparam logic [ColW-1:0] WrapCol = ColW'(TEXT_COLUMNS);
  localparam logic [RowW-1:0] RowReset =
      RowW'((BottomRowReset < TEXT_ROWS) ? BottomRowReset : TEXT_ROWS - 1);
  localparam logic [9:0] LastColW = 10'(TEXT_COLUMNS - 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_ERASE = 2'b10
  } state_e;

  state_e              st_q, st_d;
  logic [RowW-1:0]     bottom_q, bottom_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [ColW-1:0]     col_q, col_d;
  logic                rev_q, rev_d;
  logic [RowW-1:0]     er_q, er_d;
  logic [RowW-1:0]     er_end_q, er_end_d;
  erase_mode_e         mode_q, mode_d;
  logic [CapWidth-1:0] cnt_q, cnt_d;
  beat_t               out_q, out_d;

  logic            can_emit, emit;
  cmd_e            e_cmd;
  logic [7:0]      e_glyph;
  logic [RowW-1:0] e_row;
  logic [ColW-1:0] e_c0, e_c1;
  logic            e_inv, e_last;

  logic            wrap, at_bottom;
  logic [RowW-1:0] g_row;
  logic [ColW-1:0] g_col;
  logic [9:0]      n_w, row_w, col_w, bot_w;
  logic [9:0]      cup_r, cup_c, sum_r, sum_c;
  erase_mode_e     op_mode;
  logic            on_row, span_empty, fin_row, at_cap;
  logic [ColW-1:0] s_c0, s_c1;
  logic [FieldWidth-1:0] cfg_v;

  assign can_emit  = ~out_q.valid | ~out_stall_i;
  assign wrap      = (col_q >= WrapCol);
  assign at_bottom = (row_q >= bottom_q);
  assign g_row     = wrap ? row_q + 1'b1 : row_q;
  assign g_col     = wrap ? '0 : col_q;

  // CSI cursor arithmetic, 10 bits covers 255 + 31
  assign n_w   = (op_i.p0 == 8'd0) ? 10'd1 : 10'(op_i.p0);
  assign row_w = 10'(row_q);
  assign col_w = 10'(col_q);
  assign bot_w = 10'(bottom_q);
  assign cup_r = (op_i.p0 == 8'd0) ? 10'd0 : 10'(op_i.p0) - 10'd1;
  assign cup_c = (op_i.p1 == 8'd0) ? 10'd0 : 10'(op_i.p1) - 10'd1;
  assign sum_r = row_w + n_w;
  assign sum_c = col_w + n_w;

  always_comb begin
    priority if (op_i.p0 == ModeCursor) op_mode = ERASE_TO_CURSOR;
    else if (op_i.p0 == ModeAll)        op_mode = ERASE_ALL;
    else                                op_mode = ERASE_TO_END;
  end

  // span of the row under the erase walk
  assign on_row     = (er_q == row_q);
  assign s_c0       = (mode_q == ERASE_TO_END && on_row) ? col_q : '0;
  assign s_c1       = (mode_q == ERASE_TO_CURSOR && on_row && col_q < LastCol) ?
                      col_q : LastCol;
  assign span_empty = (s_c0 > s_c1);
  assign fin_row    = (er_q == er_end_q);
  assign at_cap     = (cnt_q == CapWidth'(ResultCap - 1));

  assign cfg_v = (cfg_i.value > FieldWidth'(TEXT_ROWS - 1)) ?
                 FieldWidth'(TEXT_ROWS - 1) : cfg_i.value;

  always_comb begin
    st_d     = st_q;
    bottom_d = bottom_q;
    row_d    = row_q;
    col_d    = col_q;
    rev_d    = rev_q;
    er_d     = er_q;
    er_end_d = er_end_q;
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    pop_o    = 1'b0;
    emit     = 1'b0;
    e_cmd    = CMD_GLYPH;
    e_glyph  = 8'd0;
    e_row    = '0;
    e_c0     = '0;
    e_c1     = '0;
    e_inv    = 1'b0;
    e_last   = 1'b1;

    unique case (st_q)
      ST_IDLE: begin
        if (!empty_i) begin
          unique case (op_i.kind)
            OP_GLYPH: begin
              if (can_emit) begin
                if (wrap && at_bottom) begin
                  // scroll first, glyph stays at the head for the next cycle
                  emit   = 1'b1;
                  e_cmd  = CMD_SCROLL;
                  e_last = 1'b0;
                  col_d  = '0;
                end else begin
                  emit    = 1'b1;
                  e_cmd   = CMD_GLYPH;
                  e_glyph = op_i.chr;
                  e_row   = g_row;
                  e_c0    = g_col;
                  e_inv   = rev_q;
                  row_d   = g_row;
                  col_d   = g_col + 1'b1;
                  pop_o   = 1'b1;
                end
              end
            end
            OP_BEEP: begin
              if (can_emit) begin
                emit  = 1'b1;
                e_cmd = CMD_BEEP;
                pop_o = 1'b1;
              end
            end
            OP_CR: begin
              col_d = '0;
              pop_o = 1'b1;
            end
            OP_LF: begin
              if (!at_bottom) begin
                row_d = row_q + 1'b1;
                col_d = '0;
                pop_o = 1'b1;
              end else if (can_emit) begin
                emit  = 1'b1;
                e_cmd = CMD_SCROLL;
                col_d = '0;
                pop_o = 1'b1;
              end
            end
            OP_BS: begin
              pop_o = 1'b1;
              if (col_q != '0) begin
                col_d = col_q - 1'b1;
              end else if (row_q != '0) begin
                col_d = LastCol;
                row_d = row_q - 1'b1;
              end
            end
            OP_CSI: begin
              pop_o = 1'b1;
              cnt_d = '0;
              if (op_i.chr == FinCup || op_i.chr == FinHvp) begin
                row_d = (cup_r > bot_w) ? bottom_q : RowW'(cup_r);
                col_d = (cup_c > LastColW) ? LastCol : ColW'(cup_c);
              end else if (op_i.chr == FinCuu) begin
                row_d = (n_w >= row_w) ? '0 : RowW'(row_w - n_w);
              end else if (op_i.chr == FinCud) begin
                row_d = (sum_r > bot_w) ? bottom_q : RowW'(sum_r);
              end else if (op_i.chr == FinCuf) begin
                col_d = (sum_c > LastColW) ? LastCol : ColW'(sum_c);
              end else if (op_i.chr == FinCub) begin
                col_d = (n_w >= col_w) ? '0 : ColW'(col_w - n_w);
              end else if (op_i.chr == FinEl) begin
                st_d     = ST_ERASE;
                mode_d   = op_mode;
                er_d     = row_q;
                er_end_d = row_q;
              end else if (op_i.chr == FinEd) begin
                st_d   = ST_ERASE;
                mode_d = op_mode;
                unique case (op_mode)
                  ERASE_ALL: begin
                    er_d     = '0;
                    er_end_d = bottom_q;
                  end
                  ERASE_TO_CURSOR: begin
                    er_d     = '0;
                    er_end_d = row_q;
                  end
                  default: begin
                    er_d     = row_q;
                    er_end_d = bottom_q;
                  end
                endcase
              end else if (op_i.chr == FinSgr) begin
                rev_d = (op_i.p0 == SgrReverse);
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      ST_ERASE: begin
        if (span_empty) begin
          // cursor sits in the pending-wrap column: nothing on this row
          if (fin_row) st_d = ST_IDLE;
          else         er_d = er_q + 1'b1;
        end else if (can_emit) begin
          emit   = 1'b1;
          e_cmd  = CMD_CLEAR;
          e_row  = er_q;
          e_c0   = s_c0;
          e_c1   = s_c1;
          e_last = fin_row | at_cap;
          if (fin_row || at_cap) begin
            st_d = ST_IDLE;
          end else begin
            er_d  = er_q + 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase

    if (cfg_i.wr) begin
      bottom_d = RowW'(cfg_v);
      if (row_q > RowW'(cfg_v)) row_d = RowW'(cfg_v);
    end
  end

  always_comb begin
    out_d = out_q;
    if (!out_stall_i) out_d.valid = 1'b0;
    if (emit) begin
      out_d = '{valid:     1'b1,
                command:   e_cmd,
                glyph:     e_glyph,
                cell_row:  FieldWidth'(e_row),
                col_first: FieldWidth'(e_c0),
                col_last:  FieldWidth'(e_c1),
                inverse:   e_inv,
                last:      e_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      bottom_q <= RowReset;
      row_q    <= RowReset;
      col_q    <= '0;
      rev_q    <= 1'b0;
      er_q     <= '0;
      er_end_q <= '0;
      mode_q   <= ERASE_TO_END;
      cnt_q    <= '0;
      out_q    <= '0;
    end else begin
      st_q     <= st_d;
      bottom_q <= bottom_d;
      row_q    <= row_d;
      col_q    <= col_d;
      rev_q    <= rev_d;
      er_q     <= er_d;
      er_end_q <= er_end_d;
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      out_q    <= out_d;
    end
  end

  assign bottom_row_o = FieldWidth'(bottom_q);
  assign beat_o       = out_q;

endmodule

>>> src/vt100_subset_terminal_parser.sv
// A byte's first beat reaches the result register after the byte passes the op queue.
// Throughput: 1 byte per cycle into the parser unless the op queue is full; the executor
// retires one byte a cycle unless a stalled beat holds it; a glyph that wraps at the
// bottom row first emits a scroll; erase-in-line/-display give up to 20 beats, one per cycle.
// Reset (rst_ni low, asynchronous): plain-text state, parameters cleared, reverse off,
// cursor at column 0 of row 14, bottom_row 14, queue and result register empty.
module vt100_subset_terminal_parser #(
  parameter int unsigned TEXT_COLUMNS = 30,
  parameter int unsigned TEXT_ROWS    = 20,
  parameter int unsigned MAX_VALUES   = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vtp_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [vtp_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [vtp_pkg::CfgDataWidth-1:0]  prdata,
  output logic                              pready,
  // console bytes
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        byte_in_i,
  // drawing commands
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        command_o,
  output logic [7:0]                        glyph_o,
  output logic [4:0]                        cell_row_o,
  output logic [4:0]                        col_first_o,
  output logic [4:0]                        col_last_o,
  output logic                              inverse_o,
  output logic                              last_o
);
  import vtp_pkg::*;

  // Structure:
  //   front - escape/CSI parser; owns the escape phase, the CSI values and their index.
  //           Turns each byte into zero or one op (glyph, beep, CR, LF, BS, CSI final).
  //   queue - two-entry op queue; front stalls the input only when it is full.
  //   back  - executor; owns cursor, reverse flag and bottom_row, walks erase rows one
  //           per cycle unless a stalled beat holds it, and loads the result register.
  //           A finished beat waits there while the next op is already being looked at.

  cfg_wr_t cfg_wr;
  logic    q_push, q_full, q_pop, q_empty;
  op_t     front_op, head_op;
  beat_t   beat;
  logic [FieldWidth-1:0] bottom_row;

  // Register 0 (bottom_row) at byte address 0; address bit 2 selects a register beyond it.
  assign pready       = 1'b1;
  assign cfg_wr.wr    = psel & penable & pwrite & ~paddr[RegIdxBit];
  assign cfg_wr.value = pwdata[FieldWidth-1:0];
  assign prdata       = paddr[RegIdxBit] ? '0 : CfgDataWidth'(bottom_row);

  vtp_front #(
    .MAX_VALUES(MAX_VALUES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .byte_in_i  (byte_in_i),
    .in_stall_o (in_stall_o),
    .full_i     (q_full),
    .push_o     (q_push),
    .op_o       (front_op)
  );

  vtp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (front_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .op_o    (head_op)
  );

  vtp_back #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_ROWS   (TEXT_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .bottom_row_o (bottom_row),
    .empty_i      (q_empty),
    .op_i         (head_op),
    .pop_o        (q_pop),
    .out_stall_i  (out_stall_i),
    .beat_o       (beat)
  );

  // result beat straight from the executor's output register
  assign out_valid_o = beat.valid;
  assign command_o   = beat.command;
  assign glyph_o     = beat.glyph;
  assign cell_row_o  = beat.cell_row;
  assign col_first_o = beat.col_first;
  assign col_last_o  = beat.col_last;
  assign inverse_o   = beat.inverse;
  assign last_o      = beat.last;

`include "vt100_subset_terminal_parser_assert.svh"

  // a drawn glyph never lands in the pending-wrap column
  `VTP_ASSERT_IMP(a_glyph_col, out_valid_o && command_o == CMD_GLYPH, int'(col_first_o) < TEXT_COLUMNS)
  // a beep is always the only beat of its byte
  `VTP_ASSERT_IMP(a_beep_last, out_valid_o && command_o == CMD_BEEP, last_o)
  // the beats of one byte follow each other without a gap
  `VTP_ASSERT_NXT(a_burst_next, out_valid_o && !out_stall_i && !last_o, out_valid_o)

endmodule

>>> tb/vt100_cmd_checker.sv
module vt100_cmd_checker #(
  parameter int unsigned TEXT_COLUMNS = 30,
  parameter int unsigned TEXT_ROWS    = 20,
  parameter int unsigned MAX_VALUES   = 4,
  parameter logic [vtp_pkg::CfgAddrWidth-1:0] BOTTOM_ROW_ADDR = '0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [vtp_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [vtp_pkg::CfgDataWidth-1:0] pwdata,
  input  logic                             in_valid_i,
  input  logic                             in_stall_o,
  input  logic [7:0]                       byte_in_i,
  input  logic                             out_valid_o,
  input  logic                             out_stall_i,
  input  logic [1:0]                       command_o,
  input  logic [7:0]                       glyph_o,
  input  logic [4:0]                       cell_row_o,
  input  logic [4:0]                       col_first_o,
  input  logic [4:0]                       col_last_o,
  input  logic                             inverse_o,
  input  logic                             last_o,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import vtp_pkg::*;

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESC,
    PH_CSI
  } esc_phase_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] glyph;
    logic [4:0] cell_row;
    logic [4:0] col_first;
    logic [4:0] col_last;
    logic       inverse;
    logic       last;
  } draw_cmd_t;

  draw_cmd_t   expected_cmds[$];
  esc_phase_e  phase;
  int unsigned csi_val [MAX_VALUES];
  int unsigned val_idx;
  int unsigned bottom;
  int unsigned cur_col;   // TEXT_COLUMNS means wrap pending
  int unsigned cur_row;
  int unsigned byte_cmds;
  logic        rev_video;

  function automatic void put_cmd(cmd_e c, logic [7:0] g, int unsigned r,
                                  int unsigned c0, int unsigned c1, logic inv);
    draw_cmd_t d;
    if (byte_cmds >= ResultCap) return;
    d.command   = c;
    d.glyph     = g;
    d.cell_row  = 5'(r);
    d.col_first = 5'(c0);
    d.col_last  = 5'(c1);
    d.inverse   = inv;
    d.last      = 1'b0;
    expected_cmds.push_back(d);
    byte_cmds++;
  endfunction

  function automatic void clear_span(int unsigned r, int unsigned c0, int unsigned c1);
    if (c1 > TEXT_COLUMNS - 1) c1 = TEXT_COLUMNS - 1;
    if (c0 <= c1) put_cmd(CMD_CLEAR, 8'h00, r, c0, c1, 1'b0);
  endfunction

  function automatic void line_feed();
    if (cur_row < bottom) cur_row++;
    else put_cmd(CMD_SCROLL, 8'h00, 0, 0, 0, 1'b0);
  endfunction

  // bytes after ESC and inside a CSI sequence
  function automatic void csi_byte(logic [7:0] c);
    int unsigned p0;
    int unsigned p1;
    int unsigned n;
    int unsigned v;
    int unsigned r;
    if (phase == PH_ESC) begin
      if (c == ChLbracket) begin
        phase   = PH_CSI;
        val_idx = 0;
        foreach (csi_val[i]) csi_val[i] = 0;
      end else begin
        phase = PH_TEXT;
      end
    end else if (c >= ChZero && c <= ChNine) begin
      v = csi_val[val_idx] * 10 + (c - ChZero);
      csi_val[val_idx] = (v > 255) ? 255 : v;
    end else if (c == ChSemi) begin
      if (val_idx < MAX_VALUES - 1) val_idx++;
    end else begin
      if (c >= ChAt && c <= ChTilde) begin
        p0 = csi_val[0];
        p1 = csi_val[1];
        n  = (p0 != 0) ? p0 : 1;
        case (c)
          FinCup, FinHvp: begin
            cur_row = ((p0 != 0) ? p0 : 1) - 1;
            cur_col = ((p1 != 0) ? p1 : 1) - 1;
            if (cur_row > bottom) cur_row = bottom;
            if (cur_col > TEXT_COLUMNS - 1) cur_col = TEXT_COLUMNS - 1;
          end
          FinCuu: cur_row = (n >= cur_row) ? 0 : cur_row - n;
          FinCud: begin
            cur_row += n;
            if (cur_row > bottom) cur_row = bottom;
          end
          FinCuf: begin
            cur_col += n;
            if (cur_col > TEXT_COLUMNS - 1) cur_col = TEXT_COLUMNS - 1;
          end
          FinCub: cur_col = (n >= cur_col) ? 0 : cur_col - n;
          FinEl: begin
            if (p0 == ModeCursor) clear_span(cur_row, 0, cur_col);
            else if (p0 == ModeAll) clear_span(cur_row, 0, TEXT_COLUMNS - 1);
            else clear_span(cur_row, cur_col, TEXT_COLUMNS - 1);
          end
          FinEd: begin
            if (p0 == ModeAll) begin
              for (r = 0; r <= bottom; r++) clear_span(r, 0, TEXT_COLUMNS - 1);
            end else if (p0 == ModeCursor) begin
              for (r = 0; r < cur_row; r++) clear_span(r, 0, TEXT_COLUMNS - 1);
              clear_span(cur_row, 0, cur_col);
            end else begin
              clear_span(cur_row, cur_col, TEXT_COLUMNS - 1);
              for (r = cur_row + 1; r <= bottom; r++) clear_span(r, 0, TEXT_COLUMNS - 1);
            end
          end
          FinSgr: rev_video = (p0 == SgrReverse);
          default: ;
        endcase
      end
      phase = PH_TEXT;
    end
  endfunction

  // expected drawing commands for one console byte
  function automatic void predict_byte(logic [7:0] c);
    byte_cmds = 0;
    if (phase != PH_TEXT) begin
      csi_byte(c);
    end else if (c == ChEsc) begin
      phase = PH_ESC;
    end else if (c == ChBel) begin
      put_cmd(CMD_BEEP, 8'h00, 0, 0, 0, 1'b0);
    end else if (c == ChDel) begin
      // dropped
    end else if (c == ChCr) begin
      cur_col = 0;
    end else if (c == ChLf) begin
      cur_col = 0;
      line_feed();
    end else if (c == ChBs) begin
      if (cur_col > 0) begin
        cur_col--;
      end else if (cur_row > 0) begin
        cur_col = TEXT_COLUMNS - 1;
        cur_row--;
      end
    end else begin
      if (cur_col >= TEXT_COLUMNS) begin
        cur_col = 0;
        line_feed();
      end
      put_cmd(CMD_GLYPH, c, cur_row, cur_col, 0, rev_video);
      cur_col++;
    end
    if (byte_cmds > 0) expected_cmds[expected_cmds.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    draw_cmd_t   want;
    int unsigned v;
    if (!rst_ni) begin
      expected_cmds.delete();
      phase        = PH_TEXT;
      foreach (csi_val[i]) csi_val[i] = 0;
      val_idx      = 0;
      rev_video    = 1'b0;
      cur_col      = 0;
      cur_row      = BottomRowReset;
      bottom       = BottomRowReset;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == BOTTOM_ROW_ADDR) begin
        v = pwdata[4:0];
        if (v > TEXT_ROWS - 1) v = TEXT_ROWS - 1;
        bottom = v;
        if (cur_row > bottom) cur_row = bottom;
      end
      if (in_valid_i && !in_stall_o) predict_byte(byte_in_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: command beat with nothing expected, expected none, got cmd %0d glyph %0h row %0d cols %0d..%0d inv %0b last %0b",
                   $time, command_o, glyph_o, cell_row_o, col_first_o, col_last_o,
                   inverse_o, last_o);
          fail_count_o++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("command", want.command, command_o);
          check_field("glyph", want.glyph, glyph_o);
          check_field("cell_row", want.cell_row, cell_row_o);
          check_field("col_first", want.col_first, col_first_o);
          check_field("col_last", want.col_last, col_last_o);
          check_field("inverse", want.inverse, inverse_o);
          check_field("last", want.last, last_o);
        end
      end
      pending_o = expected_cmds.size();
    end
  end

endmodule

>>> tb/tb_vt100_subset_terminal_parser.sv
module tb_vt100_subset_terminal_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import vtp_pkg::*;

  // bottom_row is register 0 -> byte address 0
  localparam logic [CfgAddrWidth-1:0] AddrBottomRow = '0;

  // cycles to let the executor finish a byte that yields no beat
  localparam int unsigned DrainCycles = 40;
  // cycles with no accepted byte, beat or register write before giving up
  localparam int unsigned StallLimit  = 5000;
  // minimum bytes per random block, 9 blocks in all
  localparam int unsigned BlockBytes  = 52;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    psel        = 1'b0;
  logic                    penable     = 1'b0;
  logic                    pwrite      = 1'b0;
  logic [CfgAddrWidth-1:0] paddr       = '0;
  logic [CfgDataWidth-1:0] pwdata      = '0;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [7:0]              byte_in_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [1:0]              command_o;
  logic [7:0]              glyph_o;
  logic [4:0]              cell_row_o;
  logic [4:0]              col_first_o;
  logic [4:0]              col_last_o;
  logic                    inverse_o;
  logic                    last_o;

  int unsigned fail_count;
  int unsigned cmds_pending;

  // idle rates in percent, changed per phase
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles    = 0;

  logic [7:0] csi_finals [9] = '{FinCup, FinHvp, FinCuu, FinCud, FinCuf, FinCub,
                                 FinEd, FinEl, FinSgr};
  logic [7:0] ctrl_bytes [5] = '{ChCr, ChLf, ChBs, ChBel, ChDel};

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  vt100_subset_terminal_parser u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .byte_in_i  (byte_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .command_o  (command_o),
    .glyph_o    (glyph_o),
    .cell_row_o (cell_row_o),
    .col_first_o(col_first_o),
    .col_last_o (col_last_o),
    .inverse_o  (inverse_o),
    .last_o     (last_o)
  );

  // Checker: predicts each command beat from the accepted bytes and the
  // register writes it sees, and compares the beats the block hands out.
  vt100_cmd_checker #(
    .BOTTOM_ROW_ADDR(AddrBottomRow)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .byte_in_i   (byte_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .command_o   (command_o),
    .glyph_o     (glyph_o),
    .cell_row_o  (cell_row_o),
    .col_first_o (col_first_o),
    .col_last_o  (col_last_o),
    .inverse_o   (inverse_o),
    .last_o      (last_o),
    .fail_count_o(fail_count),
    .pending_o   (cmds_pending)
  );

  // Receiver: stalls at random, rate set per phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: any accepted byte, beat or register write restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("vt100_subset_terminal_parser test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One console byte. Valid drops only for sender gaps; once a byte is taken
  // the next one goes straight out, so valid is never lowered and raised in
  // the same step.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Lower valid, wait for every predicted beat, then let any no-beat byte
  // still in the executor drain out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cmds_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_bottom_row(input logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrBottomRow;
    // upper bits are don't-care for a 5-bit register
    pwdata  <= {27'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One random console sequence: text runs, control bytes, well-formed CSI
  // with random parameters (mostly), or a broken escape.
  task automatic send_random_sequence(inout int unsigned sent);
    logic [7:0]  seq[$];
    logic [7:0]  b;
    int unsigned kind;
    int unsigned len;
    int unsigned nvals;
    int unsigned pick;
    int unsigned v;
    string       digits;
    kind = $urandom_range(99);
    if (kind < 32) begin
      // text run, sometimes long enough to wrap and scroll
      len = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      repeat (len) begin
        b = ($urandom_range(9) < 7) ? 8'($urandom_range(8'h20, 8'h7e))
                                    : 8'($urandom_range(0, 255));
        if (b == ChEsc) b = b ^ 8'h40;
        seq.push_back(b);
      end
    end else if (kind < 48) begin
      seq.push_back(ctrl_bytes[$urandom_range(4)]);
    end else if (kind < 88) begin
      seq.push_back(ChEsc);
      seq.push_back(ChLbracket);
      nvals = $urandom_range(0, 5);
      for (int unsigned k = 0; k < nvals; k++) begin
        if (k > 0) seq.push_back(ChSemi);
        pick = $urandom_range(99);
        // empty parameter below 15
        if (pick >= 15) begin
          if (pick < 60) v = $urandom_range(0, 9);
          else if (pick < 85) v = $urandom_range(10, 40);
          else v = $urandom_range(100, 999);
          digits = $sformatf("%0d", v);
          for (int d = 0; d < digits.len(); d++) seq.push_back(8'(digits[d]));
        end
      end
      if ($urandom_range(9) == 0) seq.push_back(8'($urandom_range(ChAt, ChTilde)));
      else seq.push_back(csi_finals[$urandom_range(8)]);
    end else if (kind < 94) begin
      // ESC followed by anything: usually dropped together with that byte
      seq.push_back(ChEsc);
      seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      // CSI cut short by a byte that is neither digit, separator nor final
      seq.push_back(ChEsc);
      seq.push_back(ChLbracket);
      seq.push_back(ChZero + 8'($urandom_range(9)));
      case ($urandom_range(2))
        0: b = 8'($urandom_range(0, 8'h2f));
        1: b = 8'($urandom_range(ChDel, 8'hff));
        default: b = ($urandom_range(1) == 0) ? 8'h3a : 8'($urandom_range(8'h3c, 8'h3f));
      endcase
      seq.push_back(b);
    end
    foreach (seq[i]) begin
      send_byte(seq[i]);
      sent++;
    end
  endtask

  initial begin : stimulus
    int unsigned send_pcts [3]  = '{30, 54, 0};
    int unsigned recv_pcts [3]  = '{54, 30, 0};
    // bottom_row per block: both extremes, an out-of-range value, then others
    int unsigned bottom_vals [9] = '{0, 19, 31, 7, 1, 14, 18, 0, 2};
    logic [7:0]  directed[$];
    int unsigned sent;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct   = send_pcts[0];
    recv_stall_pct = recv_pcts[0];

    // Directed bytes at reset settings: glyph code extremes, beep, delete,
    // backspace within a row, a glyph, then a glyph in reverse video, CR,
    // LF scrolling at the bottom row, a dropped ESC sequence, erase of the
    // whole display, saturating CUP.
    directed = '{8'h00, 8'hff, ChBel, ChDel, ChBs, 8'h5a,
                 ChEsc, ChLbracket, ChZero + 8'd7, FinSgr, 8'h80,
                 ChCr, ChLf, ChEsc, 8'h71, 8'h72,
                 ChEsc, ChLbracket, ChZero + 8'd2, FinEd,
                 ChEsc, ChLbracket, ChNine, ChNine, ChNine, FinCup};
    foreach (directed[i]) send_byte(directed[i]);

    // three idle regimes, three register settings in each
    for (int unsigned ph = 0; ph < 3; ph++) begin
      send_gap_pct   = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      for (int unsigned blk = 0; blk < 3; blk++) begin
        wait_drained();
        write_bottom_row((ph * 3 + blk == 7) ? 5'($urandom_range(31))
                                             : 5'(bottom_vals[ph * 3 + blk]));
        sent = 0;
        while (sent < BlockBytes) send_random_sequence(sent);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("vt100_subset_terminal_parser test passed");
    end else begin
      $display("vt100_subset_terminal_parser test failed");
    end
    $finish;
  end

endmodule
